>>> rtl/lpc10_frame_lattice_synth_assert.svh
// Assertion macros used by the checker file of the synthesizer.
`ifndef LPC10_FRAME_LATTICE_SYNTH_ASSERT_SVH
`define LPC10_FRAME_LATTICE_SYNTH_ASSERT_SVH

// Clocked property with reset disable and a generic message.
`define LPC10_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Same, with a caller supplied message.
`define LPC10_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

>>> rtl/lpc10_pkg.sv
package lpc10_pkg;

    localparam int FRAME_W   = 54;
    localparam int SAMPLE_W  = 16;
    localparam int BITS_W    = 6;
    localparam int STAGES    = 10;
    localparam int CHIRP_LEN = 21;

    localparam logic [0:0] OP_FRAME = 1'b0;
    localparam logic [0:0] OP_TICK  = 1'b1;

    localparam logic [3:0]  E_SILENCE = 4'h0;
    localparam logic [3:0]  E_STOP    = 4'hF;
    localparam logic [15:0] LFSR_TAPS = 16'hB800;

    localparam logic [5:0] BITS_TICK     = 6'd0;
    localparam logic [5:0] BITS_SHORT    = 6'd4;
    localparam logic [5:0] BITS_REPEAT   = 6'd11;
    localparam logic [5:0] BITS_UNVOICED = 6'd29;
    localparam logic [5:0] BITS_VOICED   = 6'd50;

    typedef enum logic [0:0] {
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef enum logic [1:0] {
        SH_7,
        SH_8,
        SH_15
    } t_mac_shift;

    typedef struct packed {
        t_mac_op    op;
        t_mac_shift shift;
    } t_mac_ctl;

    // Decoded frame, as handed from the decoder to the sequencer.
    typedef struct packed {
        logic              stop;
        logic              silence;
        logic              rep;
        logic              voiced;
        logic [7:0]        energy;
        logic [7:0]        pitch;
        logic [15:0]       k1;
        logic [15:0]       k2;
        logic [7:0][7:0]   narrow;
        logic [5:0]        bits_used;
    } t_frame_dec;

    localparam logic [7:0] ENERGY_TAB [16] = '{
        8'd0, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd10, 8'd15,
        8'd20, 8'd32, 8'd41, 8'd57, 8'd81, 8'd114, 8'd161, 8'd255};

    localparam logic [7:0] PERIOD_TAB [64] = '{
        8'd0, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
        8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30,
        8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38,
        8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd45, 8'd47, 8'd49,
        8'd51, 8'd53, 8'd54, 8'd57, 8'd59, 8'd61, 8'd63, 8'd66,
        8'd69, 8'd71, 8'd73, 8'd77, 8'd79, 8'd81, 8'd85, 8'd87,
        8'd92, 8'd95, 8'd99, 8'd102, 8'd106, 8'd110, 8'd115, 8'd119,
        8'd123, 8'd128, 8'd133, 8'd138, 8'd143, 8'd149, 8'd154, 8'd160};

    localparam logic signed [15:0] K1_TAB [32] = '{
        -16'sd32064, -16'sd31872, -16'sd31808, -16'sd31680,
        -16'sd31552, -16'sd31424, -16'sd31232, -16'sd30848,
        -16'sd30592, -16'sd30336, -16'sd30016, -16'sd29696,
        -16'sd29376, -16'sd28928, -16'sd28480, -16'sd27968,
        -16'sd26368, -16'sd24256, -16'sd21632, -16'sd18368,
        -16'sd14528, -16'sd10048, -16'sd5184,   16'sd0,
         16'sd5184,   16'sd10048,  16'sd14528,  16'sd18368,
         16'sd21632,  16'sd24256,  16'sd26368,  16'sd27968};

    localparam logic signed [15:0] K2_TAB [32] = '{
        -16'sd20992, -16'sd19328, -16'sd17536, -16'sd15552,
        -16'sd13440, -16'sd11200, -16'sd8768,  -16'sd6272,
        -16'sd3712,  -16'sd1088,   16'sd1536,   16'sd4160,
         16'sd6720,   16'sd9216,   16'sd11584,  16'sd13824,
         16'sd15936,  16'sd17856,  16'sd19648,  16'sd21248,
         16'sd22656,  16'sd24000,  16'sd25152,  16'sd26176,
         16'sd27072,  16'sd27840,  16'sd28544,  16'sd29120,
         16'sd29632,  16'sd30080,  16'sd30464,  16'sd32384};

    localparam logic signed [7:0] K3_TAB [16] = '{
        -8'sd110, -8'sd97, -8'sd83, -8'sd70, -8'sd56, -8'sd43, -8'sd29, -8'sd16,
        -8'sd2, 8'sd11, 8'sd25, 8'sd38, 8'sd52, 8'sd65, 8'sd79, 8'sd92};

    localparam logic signed [7:0] K4_TAB [16] = '{
        -8'sd82, -8'sd68, -8'sd54, -8'sd40, -8'sd26, -8'sd12, 8'sd1, 8'sd15,
        8'sd29, 8'sd43, 8'sd57, 8'sd71, 8'sd85, 8'sd99, 8'sd113, 8'sd126};

    localparam logic signed [7:0] K5_TAB [16] = '{
        -8'sd82, -8'sd70, -8'sd59, -8'sd47, -8'sd35, -8'sd24, -8'sd12, -8'sd1,
        8'sd11, 8'sd23, 8'sd34, 8'sd46, 8'sd57, 8'sd69, 8'sd81, 8'sd92};

    localparam logic signed [7:0] K6_TAB [16] = '{
        -8'sd64, -8'sd53, -8'sd42, -8'sd31, -8'sd20, -8'sd9, 8'sd3, 8'sd14,
        8'sd25, 8'sd36, 8'sd47, 8'sd58, 8'sd69, 8'sd80, 8'sd91, 8'sd102};

    localparam logic signed [7:0] K7_TAB [16] = '{
        -8'sd77, -8'sd65, -8'sd53, -8'sd41, -8'sd29, -8'sd17, -8'sd5, 8'sd7,
        8'sd19, 8'sd31, 8'sd43, 8'sd55, 8'sd67, 8'sd79, 8'sd90, 8'sd102};

    localparam logic signed [7:0] K8_TAB [8] = '{
        -8'sd64, -8'sd40, -8'sd16, 8'sd7, 8'sd31, 8'sd55, 8'sd79, 8'sd102};

    localparam logic signed [7:0] K9_TAB [8] = '{
        -8'sd64, -8'sd44, -8'sd24, -8'sd4, 8'sd16, 8'sd37, 8'sd57, 8'sd77};

    localparam logic signed [7:0] K10_TAB [8] = '{
        -8'sd51, -8'sd33, -8'sd15, 8'sd4, 8'sd22, 8'sd32, 8'sd59, 8'sd77};

    localparam logic [7:0] CHIRP_TAB [CHIRP_LEN] = '{
        8'h00, 8'h03, 8'h0f, 8'h28, 8'h4c, 8'h6c, 8'h71, 8'h50, 8'h25, 8'h26,
        8'h4c, 8'h44, 8'h1a, 8'h32, 8'h3b, 8'h13, 8'h37, 8'h1a, 8'h25, 8'h1f,
        8'h1d};

    // Chirp pulse value; zero once the counter runs past the table.
    function automatic logic [7:0] chirp_value(input logic [7:0] n);
        logic [7:0] v;
        v = '0;
        if (n < 8'(CHIRP_LEN)) begin
            v = CHIRP_TAB[n[$clog2(CHIRP_LEN)-1:0]];
        end
        return v;
    endfunction

endpackage

>>> rtl/lpc10_in_if.sv
interface lpc10_in_if;
    import lpc10_pkg::*;

    logic               valid;
    logic               ready;
    logic [0:0]         operation;
    logic [FRAME_W-1:0] frame_bits;

    modport source (output valid, output operation, output frame_bits, input ready);
    modport sink   (input valid, input operation, input frame_bits, output ready);
endinterface

>>> rtl/lpc10_out_if.sv
interface lpc10_out_if;
    import lpc10_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BITS_W-1:0]          bits_used;
    logic                       stop_seen;

    modport source (output valid, output sample, output bits_used, output stop_seen,
                    input ready);
    modport sink   (input valid, input sample, input bits_used, input stop_seen,
                    output ready);
endinterface

>>> rtl/lpc10_mac.sv
module lpc10_mac (
    input  lpc10_pkg::t_mac_ctl i_ctl,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    input  logic signed [15:0]  i_c,
    output logic signed [15:0]  o_y
);
    import lpc10_pkg::*;

    logic signed [31:0] w_prod;
    logic signed [31:0] w_scaled;
    logic [15:0]        w_term;

    // Multiply and scale with an arithmetic (floor) shift
    assign w_prod = i_a * i_b;

    always_comb begin
        unique case (i_ctl.shift)
            SH_7:    w_scaled = w_prod >>> 7;
            SH_8:    w_scaled = w_prod >>> 8;
            SH_15:   w_scaled = w_prod >>> 15;
            default: w_scaled = w_prod >>> 15;
        endcase
    end

    // Only the low 16 bits matter: the sum wraps to int16
    assign w_term = w_scaled[15:0];
    assign o_y = (i_ctl.op == MAC_SUB) ? i_c - w_term : i_c + w_term;
endmodule

>>> rtl/lpc10_decode.sv
module lpc10_decode (
    input  logic [lpc10_pkg::FRAME_W-1:0] i_bits,
    output lpc10_pkg::t_frame_dec         o_dec
);
    import lpc10_pkg::*;

    logic [3:0] w_e;
    logic [5:0] w_p;

    assign w_e = i_bits[53:50];
    assign w_p = i_bits[48:43];

    // Split the code fields and look them up
    always_comb begin
        o_dec.stop      = (w_e == E_STOP);
        o_dec.silence   = (w_e == E_SILENCE);
        o_dec.rep       = i_bits[49];
        o_dec.voiced    = (w_p != 6'd0);
        o_dec.energy    = ENERGY_TAB[w_e];
        o_dec.pitch     = PERIOD_TAB[w_p];
        o_dec.k1        = K1_TAB[i_bits[42:38]];
        o_dec.k2        = K2_TAB[i_bits[37:33]];
        o_dec.narrow[0] = K3_TAB[i_bits[32:29]];
        o_dec.narrow[1] = K4_TAB[i_bits[28:25]];
        o_dec.narrow[2] = K5_TAB[i_bits[24:21]];
        o_dec.narrow[3] = K6_TAB[i_bits[20:17]];
        o_dec.narrow[4] = K7_TAB[i_bits[16:13]];
        o_dec.narrow[5] = K8_TAB[i_bits[12:10]];
        o_dec.narrow[6] = K9_TAB[i_bits[9:7]];
        o_dec.narrow[7] = K10_TAB[i_bits[6:4]];

        // Count the consumed stream bits
        priority if (o_dec.stop || o_dec.silence) begin
            o_dec.bits_used = BITS_SHORT;
        end else if (o_dec.rep) begin
            o_dec.bits_used = BITS_REPEAT;
        end else if (!o_dec.voiced) begin
            o_dec.bits_used = BITS_UNVOICED;
        end else begin
            o_dec.bits_used = BITS_VOICED;
        end
    end
endmodule

>>> rtl/lpc10_frame_lattice_synth.sv
// Channel   Dir  Handshake       Payload
// i_req     in   valid / ready   operation, frame_bits
// o_rsp     out  valid / ready   sample, bits_used, stop_seen
//
// A frame request is decoded combinationally when taken; a new request is taken once ST_DONE returns to ST_IDLE.
// A tick request runs excitation, 10 forward and 9 backward lattice
// steps through the single shared multiply-add unit, one step per cycle, and a handoff.
// i_rst_n is synchronous, active low; it clears coefficients, delays and sets the LFSR to 1.
// A result waits in the output register while o_rsp is stalled; the block holds
// the next result and stays not ready until that register frees up.
module lpc10_frame_lattice_synth (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpc10_in_if.sink    i_req,
    lpc10_out_if.source o_rsp
);
    import lpc10_pkg::*;

    localparam int IDX_W = $clog2(STAGES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXC  = 5'b00010,
        ST_FWD  = 5'b00100,
        ST_BWD  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_pitch, n_pitch;
    logic [7:0]         r_energy, n_energy;
    logic [7:0]         r_cnt, n_cnt;
    logic [15:0]        r_lfsr, n_lfsr;
    logic signed [15:0] r_wide [2];
    logic signed [15:0] n_wide [2];
    logic [7:0]         r_narrow [8];
    logic [7:0]         n_narrow [8];
    logic signed [15:0] r_x [STAGES];
    logic signed [15:0] n_x [STAGES];
    logic signed [15:0] r_us [STAGES];
    logic signed [15:0] n_us [STAGES];
    logic signed [15:0] r_u, n_u;
    logic [5:0]         r_bits, n_bits;
    logic               r_stop, n_stop;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_sample, n_out_sample;
    logic [5:0]         r_out_bits, n_out_bits;
    logic               r_out_stop, n_out_stop;

    t_frame_dec         w_dec;
    t_mac_ctl           w_ctl;
    logic [IDX_W-1:0]   w_ksel;
    logic [2:0]         w_nsel;
    logic signed [15:0] w_coef, w_a, w_b, w_c, w_y;
    logic [7:0]         w_cnt_next;
    logic [15:0]        w_lfsr_next;
    logic [7:0]         w_chirp;
    logic               w_in_fire;

    lpc10_decode u_decode (
        .i_bits (i_req.frame_bits),
        .o_dec  (w_dec)
    );

    lpc10_mac u_mac (
        .i_ctl (w_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_y   (w_y)
    );

    assign i_req.ready     = (r_state == ST_IDLE);
    assign w_in_fire       = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sample    = r_out_sample;
    assign o_rsp.bits_used = r_out_bits;
    assign o_rsp.stop_seen = r_out_stop;

    // Pick the stage: forward reads stage idx, backward reads stage idx-1
    assign w_ksel = (r_state == ST_BWD) ? r_idx - IDX_W'(1) : r_idx;
    assign w_nsel = 3'(w_ksel - IDX_W'(2));
    assign w_coef = (w_ksel < IDX_W'(2)) ? r_wide[w_ksel[0]]
                                         : {{8{r_narrow[w_nsel][7]}}, r_narrow[w_nsel]};

    // Excitation sources
    assign w_cnt_next  = (r_cnt < r_pitch) ? r_cnt + 8'd1 : 8'd0;
    assign w_chirp     = chirp_value(w_cnt_next);
    assign w_lfsr_next = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);

    // Route operands to the shared multiply-add unit
    always_comb begin
        w_a       = w_coef;
        w_b       = r_x[w_ksel];
        w_c       = r_u;
        w_ctl.op  = MAC_SUB;
        w_ctl.shift = (w_ksel < IDX_W'(2)) ? SH_15 : SH_7;
        unique case (r_state)
            ST_EXC: begin
                w_a       = {8'd0, w_chirp};
                w_b       = {8'd0, r_energy};
                w_c       = 16'sd0;
                w_ctl.op  = MAC_ADD;
                w_ctl.shift = SH_8;
            end
            ST_BWD: begin
                w_b      = r_us[w_ksel];
                w_c      = r_x[w_ksel];
                w_ctl.op = MAC_ADD;
            end
            default: begin
                w_ctl.op = MAC_SUB;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pitch      = r_pitch;
        n_energy     = r_energy;
        n_cnt        = r_cnt;
        n_lfsr       = r_lfsr;
        n_wide       = r_wide;
        n_narrow     = r_narrow;
        n_x          = r_x;
        n_us         = r_us;
        n_u          = r_u;
        n_bits       = r_bits;
        n_stop       = r_stop;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_bits   = r_out_bits;
        n_out_stop   = r_out_stop;

        // Drop the output once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_req.operation == OP_TICK) begin
                        n_state = ST_EXC;
                    end else begin
                        // Apply the decoded frame
                        priority if (w_dec.stop) begin
                            n_energy = 8'd0;
                            n_wide   = '{default: 16'sd0};
                            n_narrow = '{default: 8'd0};
                        end else if (w_dec.silence) begin
                            n_energy = 8'd0;
                        end else begin
                            n_energy = w_dec.energy;
                            n_pitch  = w_dec.pitch;
                            if (!w_dec.rep) begin
                                n_wide[0]   = w_dec.k1;
                                n_wide[1]   = w_dec.k2;
                                n_narrow[0] = w_dec.narrow[0];
                                n_narrow[1] = w_dec.narrow[1];
                                if (w_dec.voiced) begin
                                    for (int i = 2; i < 8; i++) begin
                                        n_narrow[i] = w_dec.narrow[i];
                                    end
                                end
                            end
                        end
                        n_u     = 16'sd0;
                        n_bits  = w_dec.bits_used;
                        n_stop  = w_dec.stop;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_EXC: begin
                if (r_pitch != 8'd0) begin
                    n_cnt = w_cnt_next;
                    n_u   = w_y;
                end else begin
                    n_lfsr = w_lfsr_next;
                    n_u    = w_lfsr_next[0] ? {8'd0, r_energy} : 16'd0 - {8'd0, r_energy};
                end
                n_bits  = BITS_TICK;
                n_stop  = 1'b0;
                n_idx   = IDX_W'(STAGES - 1);
                n_state = ST_FWD;
            end
            ST_FWD: begin
                n_u         = w_y;
                n_us[r_idx] = w_y;
                if (r_idx == '0) begin
                    n_idx   = IDX_W'(STAGES - 1);
                    n_state = ST_BWD;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            ST_BWD: begin
                n_x[r_idx] = w_y;
                if (r_idx == IDX_W'(1)) begin
                    n_x[0]  = r_us[0];
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            ST_DONE: begin
                // Hand off once the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_u;
                    n_out_bits   = r_bits;
                    n_out_stop   = r_stop;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pitch     <= 8'd0;
            r_energy    <= 8'd0;
            r_cnt       <= 8'd0;
            r_lfsr      <= 16'h0001;
            r_wide      <= '{default: 16'sd0};
            r_narrow    <= '{default: 8'd0};
            r_x         <= '{default: 16'sd0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pitch     <= n_pitch;
            r_energy    <= n_energy;
            r_cnt       <= n_cnt;
            r_lfsr      <= n_lfsr;
            r_wide      <= n_wide;
            r_narrow    <= n_narrow;
            r_x         <= n_x;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_us         <= n_us;
        r_u          <= n_u;
        r_bits       <= n_bits;
        r_stop       <= n_stop;
        r_out_sample <= n_out_sample;
        r_out_bits   <= n_out_bits;
        r_out_stop   <= n_out_stop;
    end
endmodule

>>> rtl/lpc10_chk.sv
`include "lpc10_frame_lattice_synth_assert.svh"

module lpc10_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_sample,
    input logic [5:0]  i_bits_used,
    input logic        i_stop_seen
);
    import lpc10_pkg::*;

    // Hold a stalled result
    `LPC10_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample) && $stable(i_bits_used) && $stable(i_stop_seen))

    // One request at a time
    `LPC10_ASSERT_MSG(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "ready stayed high after a request")

    // Frame results carry no sample, tick results no frame info
    `LPC10_ASSERT_MSG(a_kind_split, i_clk, i_rst_n, i_out_valid |-> (i_sample == 16'h0000) || (i_bits_used == BITS_TICK && !i_stop_seen), "mixed tick and frame result")

    // A stop frame consumes only the energy code
    `LPC10_ASSERT(a_stop_bits, i_clk, i_rst_n, i_out_valid && i_stop_seen |-> i_bits_used == BITS_SHORT)

    // Bit count is one of the legal frame lengths
    `LPC10_ASSERT_MSG(a_bits_legal, i_clk, i_rst_n, i_out_valid |-> i_bits_used == BITS_TICK || i_bits_used == BITS_SHORT || i_bits_used == BITS_REPEAT || i_bits_used == BITS_UNVOICED || i_bits_used == BITS_VOICED, "illegal bit count")
endmodule

bind lpc10_frame_lattice_synth lpc10_chk u_lpc10_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_sample    (o_rsp.sample),
    .i_bits_used (o_rsp.bits_used),
    .i_stop_seen (o_rsp.stop_seen)
);
